### design/bdcs_pkg.sv
// Package: beat types, state types and codes for the bank decode and clock stretch block.
package bdcs_pkg;

    localparam logic [2:0] REGION_RAM    = 3'd0;
    localparam logic [2:0] REGION_BASIC  = 3'd1;
    localparam logic [2:0] REGION_KERNAL = 3'd2;
    localparam logic [2:0] REGION_CHAR   = 3'd3;
    localparam logic [2:0] REGION_IO     = 3'd4;
    localparam logic [2:0] REGION_PORT   = 3'd5;

    localparam logic [1:0] CFG_ROM_SELECT   = 2'd0;
    localparam logic [1:0] CFG_SPEED_MANUAL = 2'd1;
    localparam logic [1:0] CFG_MANUAL_FAST  = 2'd2;

    localparam logic       OP_WRITE = 1'b1;

    localparam logic [7:0] PORT_ZERO_RESET = 8'h00;
    localparam logic [7:0] PORT_ONE_RESET  = 8'hff;
    localparam logic [7:0] PAGE_BASIC_LO   = 8'ha0;
    localparam logic [7:0] PAGE_BASIC_HI   = 8'hc0;
    localparam logic [7:0] PAGE_IO_LO      = 8'hd0;
    localparam logic [7:0] PAGE_KERNAL_LO  = 8'he0;
    localparam logic [15:0] ROM_MASK       = 16'h1fff;
    localparam logic [15:0] CHAR_MASK      = 16'h0fff;

    typedef struct packed {
        logic        operation;
        logic [15:0] address;
        logic [7:0]  write_data;
    } t_in_beat;

    typedef struct packed {
        logic [2:0]  region;
        logic        rom_bank;
        logic [15:0] local_offset;
        logic [7:0]  port_read_data;
        logic        host_mirror;
        logic [1:0]  host_ticks;
        logic        fast_mode;
    } t_out_beat;

    typedef struct packed {
        logic [7:0] port_zero;
        logic [7:0] port_one;
        logic       soft_slow;
        logic [1:0] fast_phase;
    } t_port_state;

    typedef struct packed {
        logic rom_select;
        logic speed_manual;
        logic manual_fast;
    } t_cfg;

endpackage

### design/bdcs_decode.sv
// Combinational bank decode, port update and host tick accounting for one access.
module bdcs_decode (
    input  bdcs_pkg::t_in_beat    i_beat,
    input  bdcs_pkg::t_port_state i_state,
    input  bdcs_pkg::t_cfg        i_cfg,
    output bdcs_pkg::t_out_beat   o_result,
    output bdcs_pkg::t_port_state o_state
);

    logic       wr;
    logic [7:0] page;
    logic [2:0] map;
    logic       fast;
    logic       fast_after;
    logic [1:0] phase_inc;
    logic       stretch;
    logic       in_io_page;

    assign wr         = (i_beat.operation == bdcs_pkg::OP_WRITE);
    assign page       = i_beat.address[15:8];
    assign map        = i_state.port_one[2:0];
    assign fast       = (!i_cfg.speed_manual && !i_state.soft_slow) ||
                        (i_cfg.speed_manual && i_cfg.manual_fast);
    assign phase_inc  = i_state.fast_phase + 2'd1;
    assign in_io_page = (page >= bdcs_pkg::PAGE_IO_LO) && (page < bdcs_pkg::PAGE_KERNAL_LO);

    always_comb begin
        o_result                = '0;
        o_result.region         = bdcs_pkg::REGION_RAM;
        o_result.local_offset   = i_beat.address;
        o_state                 = i_state;
        stretch                 = 1'b0;

        if (i_beat.address[15:1] == 15'd0) begin
            o_result.region = bdcs_pkg::REGION_PORT;
            if (!wr) begin
                o_result.port_read_data = i_beat.address[0] ? i_state.port_one
                                                            : i_state.port_zero;
            end else if (!i_beat.address[0]) begin
                o_state.port_zero = i_beat.write_data;
                o_state.soft_slow = i_beat.write_data[7];
            end else begin
                o_state.port_one = i_beat.write_data;
            end
        end else if (in_io_page) begin
            if (map >= 3'd5) begin
                o_result.region = bdcs_pkg::REGION_IO;
                stretch         = 1'b1;
            end else if (!wr && map >= 3'd1 && map <= 3'd3) begin
                o_result.region       = bdcs_pkg::REGION_CHAR;
                o_result.local_offset = i_beat.address & bdcs_pkg::CHAR_MASK;
            end
        end else if (wr) begin
            o_result.host_mirror = 1'b1;
            stretch              = 1'b1;
        end else begin
            if (page >= bdcs_pkg::PAGE_BASIC_LO && page < bdcs_pkg::PAGE_BASIC_HI &&
                map[1:0] == 2'd3) begin
                o_result.region = bdcs_pkg::REGION_BASIC;
            end else if (page >= bdcs_pkg::PAGE_KERNAL_LO && map[1]) begin
                o_result.region = bdcs_pkg::REGION_KERNAL;
            end
            if (o_result.region != bdcs_pkg::REGION_RAM) begin
                o_result.rom_bank     = i_cfg.rom_select;
                o_result.local_offset = i_beat.address & bdcs_pkg::ROM_MASK;
            end
        end

        // host tick accounting: speed in force before any port write
        if (!fast) begin
            o_result.host_ticks = 2'd1;
        end else if (stretch) begin
            o_result.host_ticks = 2'd2;
            o_state.fast_phase  = 2'd0;
        end else begin
            o_result.host_ticks = (phase_inc == 2'd0) ? 2'd1 : 2'd0;
            o_state.fast_phase  = phase_inc;
        end

        o_result.fast_mode = fast_after;
    end

    assign fast_after = (!i_cfg.speed_manual && !o_state.soft_slow) ||
                        (i_cfg.speed_manual && i_cfg.manual_fast);

endmodule

### design/bank_decode_and_clock_stretch.sv
// Top level: bus access bank decode with port registers, config and a result register.
// Each accepted input beat's result is registered into the output register.
// Throughput: one beat per cycle unless stalled; the decode is a single combinational pass into the output register.
// The input stalls only while the output register is full and its own beat is stalled.
// Reset (synchronous, active low) empties the output register, sets port 0 to 0x00,
// port 1 to 0xff, soft speed fast, phase 0, and config to ROM set 0, soft speed, switch fast.
module bank_decode_and_clock_stretch (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  bdcs_pkg::t_in_beat  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output bdcs_pkg::t_out_beat o_out_data,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_index,
    input  logic                i_cfg_wdata
);

    bdcs_pkg::t_port_state r_state;
    bdcs_pkg::t_port_state n_state;
    bdcs_pkg::t_cfg        r_cfg;
    bdcs_pkg::t_out_beat   r_out;
    bdcs_pkg::t_out_beat   n_out;
    logic                  r_out_valid;
    logic                  in_accept;

    assign o_in_stall  = r_out_valid && i_out_stall;
    assign in_accept   = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    bdcs_decode u_decode (
        .i_beat   (i_in_data),
        .i_state  (r_state),
        .i_cfg    (r_cfg),
        .o_result (n_out),
        .o_state  (n_state)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.port_zero  <= bdcs_pkg::PORT_ZERO_RESET;
            r_state.port_one   <= bdcs_pkg::PORT_ONE_RESET;
            r_state.soft_slow  <= 1'b0;
            r_state.fast_phase <= 2'd0;
        end else if (in_accept) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.rom_select   <= 1'b0;
            r_cfg.speed_manual <= 1'b0;
            r_cfg.manual_fast  <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                bdcs_pkg::CFG_ROM_SELECT: begin
                    r_cfg.rom_select <= i_cfg_wdata;
                end
                bdcs_pkg::CFG_SPEED_MANUAL: begin
                    r_cfg.speed_manual <= i_cfg_wdata;
                end
                bdcs_pkg::CFG_MANUAL_FAST: begin
                    r_cfg.manual_fast <= i_cfg_wdata;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_out <= n_out;
        end
    end

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !r_out_valid)
        else $error("output register not empty after reset");

    a_stretch_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && n_out.host_ticks == 2'd2) |=> r_state.fast_phase == 2'd0)
        else $error("stretched access did not clear the fast phase");

    a_mirror_ram: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.host_mirror) |-> r_out.region == bdcs_pkg::REGION_RAM)
        else $error("host mirror outside RAM region");

    a_bank_rom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.rom_bank) |->
            (r_out.region == bdcs_pkg::REGION_BASIC || r_out.region == bdcs_pkg::REGION_KERNAL))
        else $error("ROM bank set outside ROM regions");

    a_port_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.region != bdcs_pkg::REGION_PORT) |-> r_out.port_read_data == 8'd0)
        else $error("port data outside a port access");

endmodule
